@@ rtl/core/hogd_pkg.sv @@
package hogd_pkg;

    // Name field length of one entry
    localparam int NAME_BYTES = 13;

    // Byte index counter: wide enough for the name, size field and magic
    localparam int CNT_W = ($clog2(NAME_BYTES) > 2) ? $clog2(NAME_BYTES) : 2;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_MAGIC = 4'b0001,
        PH_NAME  = 4'b0010,
        PH_SIZE  = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    // Section tags on the output
    localparam logic [1:0] SEC_MAGIC = 2'd0;
    localparam logic [1:0] SEC_NAME  = 2'd1;
    localparam logic [1:0] SEC_SIZE  = 2'd2;
    localparam logic [1:0] SEC_DATA  = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_VALID_END  = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
    localparam logic [2:0] ST_TRUNC_HDR  = 3'd3;
    localparam logic [2:0] ST_TRUNC_DATA = 3'd4;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] section;
        logic       entry_start;
        logic       coded_entry;
        logic [2:0] status;
        logic       end_of_archive;
    } result_t;

    // Parser state seen by the top level
    typedef struct packed {
        phase_t     phase;
        logic       magic_err;
    } parse_state_t;

endpackage

@@ rtl/core/hogd_parser.sv @@
module hogd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  final_byte,
    output hogd_pkg::result_t     result,
    output hogd_pkg::parse_state_t state
);

    localparam logic [7:0] MAGIC_0 = 8'h44;
    localparam logic [7:0] MAGIC_1 = 8'h48;
    localparam logic [7:0] MAGIC_2 = 8'h46;
    localparam logic [hogd_pkg::CNT_W:0] MAGIC_LEN = (hogd_pkg::CNT_W + 1)'(3);
    localparam logic [hogd_pkg::CNT_W:0] SIZE_LEN  = (hogd_pkg::CNT_W + 1)'(4);
    localparam logic [hogd_pkg::CNT_W:0] NAME_LEN  =
        (hogd_pkg::CNT_W + 1)'(hogd_pkg::NAME_BYTES);

    function automatic logic [7:0] lower_char(input logic [7:0] c);
        lower_char = (c inside {[8'h41:8'h5A]}) ? c + 8'h20 : c;
    endfunction

    function automatic logic tail_is_coded(input logic [31:0] tail);
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        c1 = lower_char(tail[23:16]);
        c2 = lower_char(tail[15:8]);
        c3 = lower_char(tail[7:0]);
        tail_is_coded = (tail[31:24] == 8'h2E) && (c2 == 8'h74) && (c3 == 8'h62)
                        && ((c1 == 8'h74) || (c1 == 8'h63));
    endfunction

    function automatic logic [7:0] decode_byte(input logic [7:0] b);
        if (b == 8'h0A || b == 8'h8F)
            decode_byte = b;
        else
            decode_byte = {b[5:0], b[7:6]} ^ 8'hA7;
    endfunction

    hogd_pkg::phase_t          phase_reg, phase_next;
    logic [hogd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]               acc_reg, acc_next;
    logic [31:0]               remain_reg, remain_next;
    logic [31:0]               tail_reg, tail_next;
    logic                      ended_reg, ended_next;
    logic                      coded_reg, coded_next;
    logic                      err_reg, err_next;
    logic                      decode_enable_reg;
    logic [hogd_pkg::CNT_W:0]  cnt_inc;
    logic [7:0]                magic_want;
    logic [31:0]               size_full;

    // Hold the decode enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decode_enable_reg <= 1'b1;
        else if (cfg_wr_en)
            decode_enable_reg <= cfg_wr_data;
    end

    assign cnt_inc   = {1'b0, cnt_reg} + 1'b1;
    assign size_full = acc_reg | ({24'd0, data_byte} << {cnt_reg[1:0], 3'b000});

    // Advance the parse for one byte and form its result
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        tail_next   = tail_reg;
        ended_next  = ended_reg;
        coded_next  = coded_reg;
        err_next    = err_reg;
        magic_want  = MAGIC_2;

        result.out_byte       = data_byte;
        result.section        = hogd_pkg::SEC_MAGIC;
        result.entry_start    = 1'b0;
        result.coded_entry    = 1'b0;
        result.status         = hogd_pkg::ST_OK;
        result.end_of_archive = final_byte;

        case (phase_reg)
            hogd_pkg::PH_MAGIC:
            begin
                result.section = hogd_pkg::SEC_MAGIC;
                if (cnt_reg == '0)
                    magic_want = MAGIC_0;
                else if (cnt_reg == hogd_pkg::CNT_W'(1))
                    magic_want = MAGIC_1;
                if (data_byte != magic_want)
                    err_next = 1'b1;
                cnt_next = cnt_inc[hogd_pkg::CNT_W-1:0];
                if (cnt_inc >= MAGIC_LEN)
                begin
                    phase_next = hogd_pkg::PH_NAME;
                    cnt_next   = '0;
                end
            end
            hogd_pkg::PH_NAME:
            begin
                result.section = hogd_pkg::SEC_NAME;
                if (cnt_reg == '0)
                begin
                    result.entry_start = 1'b1;
                    if (data_byte == 8'h00)
                    begin
                        ended_next = 1'b1;
                        tail_next  = '0;
                    end
                    else
                    begin
                        ended_next = 1'b0;
                        tail_next  = {24'd0, data_byte};
                    end
                end
                else if (!ended_reg)
                begin
                    if (data_byte == 8'h00)
                        ended_next = 1'b1;
                    else
                        tail_next = {tail_reg[23:0], data_byte};
                end
                cnt_next = cnt_inc[hogd_pkg::CNT_W-1:0];
                if (cnt_inc >= NAME_LEN)
                begin
                    coded_next = tail_is_coded(tail_next);
                    phase_next = hogd_pkg::PH_SIZE;
                    cnt_next   = '0;
                    acc_next   = '0;
                end
            end
            hogd_pkg::PH_SIZE:
            begin
                result.section = hogd_pkg::SEC_SIZE;
                acc_next = size_full;
                cnt_next = cnt_inc[hogd_pkg::CNT_W-1:0];
                if (cnt_inc >= SIZE_LEN)
                begin
                    remain_next = size_full;
                    phase_next  = (size_full != '0) ? hogd_pkg::PH_DATA : hogd_pkg::PH_NAME;
                    cnt_next    = '0;
                end
            end
            hogd_pkg::PH_DATA:
            begin
                result.section     = hogd_pkg::SEC_DATA;
                result.coded_entry = coded_reg;
                if (coded_reg && decode_enable_reg)
                    result.out_byte = decode_byte(data_byte);
                if (remain_reg != '0)
                    remain_next = remain_reg - 32'd1;
                if (remain_reg <= 32'd1)
                begin
                    phase_next = hogd_pkg::PH_NAME;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                phase_next = hogd_pkg::PH_MAGIC;
                cnt_next   = '0;
            end
        endcase

        // Form the status; on the last byte judge where the archive stopped
        if (!final_byte)
            result.status = err_next ? hogd_pkg::ST_BAD_MAGIC : hogd_pkg::ST_OK;
        else if (err_next)
            result.status = hogd_pkg::ST_BAD_MAGIC;
        else if (phase_next == hogd_pkg::PH_MAGIC)
            result.status = hogd_pkg::ST_BAD_MAGIC;
        else if (phase_next == hogd_pkg::PH_NAME && cnt_next == '0)
            result.status = hogd_pkg::ST_VALID_END;
        else if (phase_next == hogd_pkg::PH_NAME || phase_next == hogd_pkg::PH_SIZE)
            result.status = hogd_pkg::ST_TRUNC_HDR;
        else
            result.status = hogd_pkg::ST_TRUNC_DATA;
    end

    // Update parse state on each transfer; drop it all after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hogd_pkg::PH_MAGIC;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            remain_reg <= '0;
            tail_reg   <= '0;
            ended_reg  <= 1'b0;
            coded_reg  <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                phase_reg  <= hogd_pkg::PH_MAGIC;
                cnt_reg    <= '0;
                acc_reg    <= '0;
                remain_reg <= '0;
                tail_reg   <= '0;
                ended_reg  <= 1'b0;
                coded_reg  <= 1'b0;
                err_reg    <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                cnt_reg    <= cnt_next;
                acc_reg    <= acc_next;
                remain_reg <= remain_next;
                tail_reg   <= tail_next;
                ended_reg  <= ended_next;
                coded_reg  <= coded_next;
                err_reg    <= err_next;
            end
        end
    end

    assign state.phase     = phase_reg;
    assign state.magic_err = err_reg;

endmodule

@@ rtl/core/hogd_out_stage.sv @@
module hogd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  hogd_pkg::result_t result_in,
    input  logic              ready,
    output logic              valid,
    output logic              space,
    output hogd_pkg::result_t result_out
);

    logic              valid_reg;
    hogd_pkg::result_t data_reg;

    // Room for a new result when empty or the held one leaves this cycle
    assign space = !valid_reg || ready;

    // Track occupancy of the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (ready)
            valid_reg <= 1'b0;
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign valid      = valid_reg;
    assign result_out = data_reg;

endmodule

@@ rtl/core/hog_archive_stream_deframer.sv @@
// Archive stream deframer.
// Input stream s_axis: one archive byte per transfer, tlast on the last byte.
// Output stream m_axis: one result per input byte, in order, tlast echoes the
// input tlast and carries the final status (valid end or the kind of fault).
// The parser checks the three-byte magic, then walks entries of a fixed-size
// name, a 4-byte little-endian size and the data; data of .ttb/.ctb entries
// is decoded when decode_enable is set (cfg_wr_en/cfg_wr_data, reset 1).
// A result is registered and appears in the cycle after its byte is taken.
// Throughput: one byte per cycle while the receiver keeps up; the parse state
// update and the single result register set that figure. The input is ready
// whenever the result register is empty or its result is taken in the same
// cycle, so a stalled receiver holds the result and stops input only while it holds it.
// Reset clears the parse state to the magic phase, empties the result
// register and sets decode_enable to 1. After each last byte the parse state
// returns to the magic phase for the next archive.
module hog_archive_stream_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic [3:0]  m_axis_tuser,   // [1:0] section, [2] entry_start, [3] coded_entry
    output logic        m_axis_tlast    // end_of_archive
);

    logic                   accept;
    logic                   space;
    hogd_pkg::result_t      result_comb;
    hogd_pkg::result_t      result_held;
    hogd_pkg::parse_state_t parse_state;

    assign s_axis_tready = space;
    assign accept        = s_axis_tvalid && space;

    hogd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .result     (result_comb),
        .state      (parse_state)
    );

    hogd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result_in (result_comb),
        .ready     (m_axis_tready),
        .valid     (m_axis_tvalid),
        .space     (space),
        .result_out(result_held)
    );

    // Pack the result onto the output stream
    assign m_axis_tdata = {5'd0, result_held.status, result_held.out_byte};
    assign m_axis_tuser = {result_held.coded_entry, result_held.entry_start,
                           result_held.section};
    assign m_axis_tlast = result_held.end_of_archive;

`ifndef SYNTH
    // Every transfer in produces a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    // After the last byte the parser is back in the magic phase, error cleared
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tlast) |=>
            (parse_state.phase == hogd_pkg::PH_MAGIC) && !parse_state.magic_err)
        else $error("parser did not restart after last byte");

    // Only ok or bad magic may show before the end of an archive
    a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
            (m_axis_tdata[10:8] == hogd_pkg::ST_OK ||
             m_axis_tdata[10:8] == hogd_pkg::ST_BAD_MAGIC))
        else $error("final status shown before last byte");

    // Entry start and coded flag only in their sections
    a_flag_sections: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (!m_axis_tuser[2] || m_axis_tuser[1:0] == hogd_pkg::SEC_NAME) &&
            (!m_axis_tuser[3] || m_axis_tuser[1:0] == hogd_pkg::SEC_DATA))
        else $error("flag outside its section");
`endif

endmodule

@@ bench/archive_checker.sv @@
module archive_checker
    import hogd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] MAGIC_0    = "D";
    localparam logic [7:0] MAGIC_1    = "H";
    localparam logic [7:0] MAGIC_2    = "F";
    localparam logic [7:0] CIPHER_KEY = 8'hA7;
    localparam logic [7:0] KEEP_LF    = 8'h0A;
    localparam logic [7:0] KEEP_8F    = 8'h8F;
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_T       = "t";
    localparam logic [7:0] CH_C       = "c";
    localparam logic [7:0] CH_B       = "b";
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // Shadow copy of the parser state and the decode register
    phase_t      ph;
    logic [4:0]  idx;
    logic [31:0] size_acc;
    logic [31:0] data_left;
    logic [31:0] name_tail;
    logic        name_done;
    logic        coded_name;
    logic        decode_on;
    logic [2:0]  sticky_err;

    result_t     expected_results[$];
    result_t     got;
    result_t     want;
    result_t     fresh;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | CASE_BIT) : c;
    endfunction

    // A coded name ends in '.', 't' or 'c', 't', 'b', in any case
    function automatic logic coded_suffix(input logic [31:0] tail);
        logic [7:0] c1;
        c1 = fold_case(tail[23:16]);
        return tail[31:24] == CH_DOT && (c1 == CH_T || c1 == CH_C)
            && fold_case(tail[15:8]) == CH_T && fold_case(tail[7:0]) == CH_B;
    endfunction

    // Rotate left by two, then XOR with the key; line feed and 0x8F pass as they are
    function automatic logic [7:0] text_decode(input logic [7:0] b);
        if (b == KEEP_LF || b == KEEP_8F)
            return b;
        return {b[5:0], b[7:6]} ^ CIPHER_KEY;
    endfunction

    function automatic logic [7:0] magic_char(input logic [4:0] i);
        case (i)
            5'd0:    return MAGIC_0;
            5'd1:    return MAGIC_1;
            default: return MAGIC_2;
        endcase
    endfunction

    task automatic clear_parse();
        ph         = PH_MAGIC;
        idx        = '0;
        size_acc   = '0;
        data_left  = '0;
        name_tail  = '0;
        name_done  = 1'b0;
        coded_name = 1'b0;
        sticky_err = ST_OK;
    endtask

    // Advance the shadow parser by one byte and form the result it produces
    task automatic parse_byte(input logic [7:0] b, input logic fin, output result_t r);
        r = '0;
        r.out_byte = b;
        r.end_of_archive = fin;
        case (ph)
            PH_MAGIC:
            begin
                r.section = SEC_MAGIC;
                if (b != magic_char(idx) && sticky_err == ST_OK)
                    sticky_err = ST_BAD_MAGIC;
                idx++;
                if (idx == 5'd3)
                begin
                    ph  = PH_NAME;
                    idx = '0;
                end
            end
            PH_NAME:
            begin
                r.section = SEC_NAME;
                if (idx == 5'd0)
                begin
                    r.entry_start = 1'b1;
                    name_tail     = '0;
                    name_done     = 1'b0;
                end
                // Keep the last four bytes before the first NUL
                if (!name_done)
                begin
                    if (b == 8'h00)
                        name_done = 1'b1;
                    else
                        name_tail = {name_tail[23:0], b};
                end
                idx++;
                if (idx == NAME_BYTES)
                begin
                    coded_name = coded_suffix(name_tail);
                    ph         = PH_SIZE;
                    idx        = '0;
                    size_acc   = '0;
                end
            end
            PH_SIZE:
            begin
                r.section = SEC_SIZE;
                size_acc  = size_acc | ({24'd0, b} << (8 * idx[1:0]));
                idx++;
                if (idx == 5'd4)
                begin
                    data_left = size_acc;
                    ph        = (data_left != 0) ? PH_DATA : PH_NAME;
                    idx       = '0;
                end
            end
            default:
            begin
                r.section     = SEC_DATA;
                r.coded_entry = coded_name;
                if (coded_name && decode_on)
                    r.out_byte = text_decode(b);
                if (data_left != 0)
                    data_left--;
                if (data_left == 0)
                begin
                    ph  = PH_NAME;
                    idx = '0;
                end
            end
        endcase

        // Recorded errors win over any truncation on the last byte
        if (!fin)
            r.status = sticky_err;
        else
        begin
            if (sticky_err != ST_OK)
                r.status = sticky_err;
            else if (ph == PH_MAGIC)
                r.status = ST_BAD_MAGIC;
            else if (ph == PH_NAME && idx == 5'd0)
                r.status = ST_VALID_END;
            else if (ph == PH_NAME || ph == PH_SIZE)
                r.status = ST_TRUNC_HDR;
            else
                r.status = ST_TRUNC_DATA;
            clear_parse();
        end
    endtask

    task automatic flag(input string msg);
        if (mismatch_count < 10)
            $display("%s", msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            decode_on = 1'b1;
            expected_results.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            // Compare each output transfer with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got.out_byte       = m_tdata[7:0];
                got.status         = m_tdata[10:8];
                got.section        = m_tuser[1:0];
                got.entry_start    = m_tuser[2];
                got.coded_entry    = m_tuser[3];
                got.end_of_archive = m_tlast;
                if (expected_results.size() == 0)
                    flag($sformatf("%0t: output transfer with nothing expected, byte %h",
                        $realtime, got.out_byte));
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[15:11] !== 5'd0)
                        flag($sformatf({"%0t: expected byte %h sec %0d start %b coded %b",
                            " status %0d last %b; got byte %h sec %0d start %b coded %b",
                            " status %0d last %b pad %h"}, $realtime,
                            want.out_byte, want.section, want.entry_start,
                            want.coded_entry, want.status, want.end_of_archive,
                            got.out_byte, got.section, got.entry_start,
                            got.coded_entry, got.status, got.end_of_archive,
                            m_tdata[15:11]));
                end
            end

            // Predict the result of each input transfer
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast, fresh);
                expected_results.push_back(fresh);
            end

            if (cfg_wr_en)
                decode_on = cfg_wr_data;

            outstanding = expected_results.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hogd_pkg::*;

    localparam int PERIOD      = 20;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_BYTES = 150;
    localparam int IDLE_PCT    = 30;

    localparam logic [7:0] MAGIC_0  = "D";
    localparam logic [7:0] MAGIC_1  = "H";
    localparam logic [7:0] MAGIC_2  = "F";
    localparam logic [7:0] CASE_BIT = 8'h20;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          mismatch_count;
    int          outstanding;
    int          bytes_sent;
    int          stall_cycles;
    bit          steady;
    bit          hold_req;
    logic [7:0]  arc[$];

    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    hog_archive_stream_deframer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    archive_checker check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tlast        (s_axis_tlast),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .m_tlast        (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial
    begin : receiver
        int n;
        forever
        begin
            if (hold_req)
            begin
                for (n = 0; n < HOLD_CYCLES; n++)
                begin
                    m_axis_tready <= 1'b0;
                    @(posedge clk);
                end
                hold_req = 1'b0;
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge clk);
        end
    end

    // Offer one byte, idling first at random, and hold it until the transfer
    task automatic push(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_archive();
        int i;
        for (i = 0; i < arc.size(); i++)
            push(arc[i], i == arc.size() - 1);
    endtask

    // Drop valid and wait until every result has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_decode(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        return $urandom_range(0, 1) ? (c & ~CASE_BIT) : c;
    endfunction

    // Entry data: mostly random, with the pass-through bytes favored
    function automatic logic [7:0] data_value();
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, 1) ? 8'h0A : 8'h8F;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_magic();
        arc.push_back(MAGIC_0);
        arc.push_back(MAGIC_1);
        arc.push_back(MAGIC_2);
        if ($urandom_range(0, 9) == 0)
            arc[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
    endtask

    task automatic add_name();
        logic [7:0] nm [NAME_BYTES];
        int mode;
        int len;
        int i;
        for (i = 0; i < NAME_BYTES; i++)
            nm[i] = 8'($urandom_range(0, 255));
        mode = $urandom_range(0, 9);
        if (mode <= 6)
        begin
            // Prefix, then a coded suffix; near misses corrupt it
            len = $urandom_range(0, NAME_BYTES - 4);
            for (i = 0; i < len; i++)
                nm[i] = 8'($urandom_range(1, 255));
            nm[len]     = ".";
            nm[len + 1] = mixed_case($urandom_range(0, 1) ? "t" : "c");
            nm[len + 2] = mixed_case("t");
            nm[len + 3] = mixed_case("b");
            if (len + 4 < NAME_BYTES)
                nm[len + 4] = 8'h00;
            if (mode == 5)
                nm[len + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
            if (mode == 6)
                nm[len + 2] = mixed_case("x");
        end
        else if (mode == 7)
        begin
            // Short name; a suffix after the NUL must be ignored
            len = $urandom_range(0, 3);
            for (i = 0; i < len; i++)
                nm[i] = 8'($urandom_range(1, 255));
            nm[len]     = 8'h00;
            nm[len + 1] = ".";
            nm[len + 2] = "t";
            nm[len + 3] = "t";
            nm[len + 4] = "b";
        end
        for (i = 0; i < NAME_BYTES; i++)
            arc.push_back(nm[i]);
    endtask

    task automatic add_size(input logic [31:0] n);
        arc.push_back(n[7:0]);
        arc.push_back(n[15:8]);
        arc.push_back(n[23:16]);
        arc.push_back(n[31:24]);
    endtask

    task automatic add_entry();
        int n;
        add_name();
        if ($urandom_range(0, 9) == 0)
            n = 0;
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(20, 40);
        else
            n = $urandom_range(1, 10);
        add_size(n);
        repeat (n) arc.push_back(data_value());
    endtask

    // Whole archives mostly; some cut short, some end inside a huge entry
    task automatic build_archive();
        int n_entries;
        int kind;
        int cut;
        arc.delete();
        add_magic();
        n_entries = $urandom_range(0, 3);
        repeat (n_entries) add_entry();
        kind = $urandom_range(0, 9);
        if (kind >= 8)
        begin
            add_name();
            add_size($urandom());
            repeat ($urandom_range(0, 6)) arc.push_back(data_value());
        end
        else if (kind >= 6 && arc.size() > 1)
        begin
            cut = $urandom_range(1, arc.size() - 1);
            while (arc.size() > cut)
                void'(arc.pop_back());
        end
    endtask

    initial
    begin : stimulus
        int p;
        int goal;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coded entry with pass-through bytes and junk after the NUL, then a one-byte archive
        arc = {MAGIC_0, MAGIC_1, MAGIC_2,
               8'("A"), 8'("."), 8'("C"), 8'("T"), 8'("B"), 8'h00,
               8'("."), 8'("t"), 8'("x"), 8'("b"), 8'hFF, 8'h80, 8'h01,
               8'h03, 8'h00, 8'h00, 8'h00,
               8'h0A, 8'h8F, 8'hFF};
        send_archive();
        arc = {8'h00};
        send_archive();
        drain();

        // Alternate the decode setting; hold off the receiver once, run one phase without idling
        for (p = 0; p < 4; p++)
        begin
            write_decode(p[0]);
            steady   = (p == 2);
            hold_req = (p == 1);
            goal     = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal)
            begin
                build_archive();
                send_archive();
            end
            drain();
        end
        steady = 1'b0;

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
